@@ rtl/lpd_pkg.sv @@
// shared types and constants for the length prefix deframer
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int BYTE_W   = 8;
    localparam int REG_W    = 32;
    localparam int POS_W    = 35;
    localparam int FLEN_W   = 34;
    localparam int CIDX_W   = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_HEADER_OFFSET = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_EXTRA_LENGTH  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BIG_ENDIAN    = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1
    } phase_t;

    // frame_base is header_offset + field bytes + extra_length, two's complement
    typedef struct packed {
        logic [REG_W-1:0] header_offset;
        logic [POS_W-1:0] frame_base;
        logic             big_endian;
    } cfg_t;

    typedef struct packed {
        logic              frame_end;
        logic [FLEN_W-1:0] frame_length;
    } res_t;

endpackage

@@ rtl/length_prefix_deframer_core.sv @@
// top level of the length prefix deframer: handshake, config registers, result register
//
// usage:
//   input channel  in_valid / in_stall carries stream_byte, one byte per transaction
//   output channel out_valid / out_stall carries out_byte, frame_end, frame_length,
//   exactly one output transaction for every input transaction, in order
//   config channel cfg_valid / cfg_ready writes header_offset (0), extra_length (1)
//   and big_endian (2); other indexes are dropped; cfg_ready is always high
//   frame_end marks the byte that closes a frame, frame_length its byte count
// timing:
//   an input byte passes through the input register, then the frame tracker logic
//   feeding the result register
//   throughput is one byte per cycle while the output is not stalled, set by the tracker update
// reset:
//   rst_n clears both valid flags, the frame state and the config registers but
//   frame_base (set to LENGTH_FIELD_BYTES); no clearing pass, bytes are taken at once
// stall:
//   a stalled result holds; the input register keeps filling behind it, so
//   in_stall rises only when both the input and result registers are full
`timescale 1ns / 1ps

module length_prefix_deframer_core #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lpd_pkg::BYTE_W-1:0]  stream_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lpd_pkg::BYTE_W-1:0]  out_byte,
    output logic                        frame_end,
    output logic [lpd_pkg::FLEN_W-1:0]  frame_length,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lpd_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [lpd_pkg::REG_W-1:0]   cfg_data
);

    // input register
    logic                       s1_valid_reg, s1_valid_next;
    logic [lpd_pkg::BYTE_W-1:0] s1_byte_reg;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [lpd_pkg::BYTE_W-1:0] out_byte_reg;
    lpd_pkg::res_t              out_res_reg;

    // config registers; frame_base is kept up to date at every write
    logic [lpd_pkg::REG_W-1:0]  hdr_reg, hdr_next;
    logic [lpd_pkg::REG_W-1:0]  extra_reg, extra_next;
    logic                       be_reg, be_next;
    logic [lpd_pkg::POS_W-1:0]  base_reg, base_next;

    logic                       accept_in;
    logic                       advance;
    lpd_pkg::cfg_t              cfg;
    lpd_pkg::res_t              res;

    // the input register moves on whenever the result register is free or draining
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = accept_in || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // config write decode
    always_comb
    begin
        hdr_next   = hdr_reg;
        extra_next = extra_reg;
        be_next    = be_reg;
        base_next  = base_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lpd_pkg::CFG_HEADER_OFFSET:
                begin
                    hdr_next  = cfg_data;
                    base_next = lpd_pkg::POS_W'(cfg_data)
                              + lpd_pkg::POS_W'(LENGTH_FIELD_BYTES)
                              + {{3{extra_reg[lpd_pkg::REG_W-1]}}, extra_reg};
                end
                lpd_pkg::CFG_EXTRA_LENGTH:
                begin
                    extra_next = cfg_data;
                    base_next  = lpd_pkg::POS_W'(hdr_reg)
                               + lpd_pkg::POS_W'(LENGTH_FIELD_BYTES)
                               + {{3{cfg_data[lpd_pkg::REG_W-1]}}, cfg_data};
                end
                lpd_pkg::CFG_BIG_ENDIAN:
                begin
                    be_next = cfg_data[0];
                end
                default:
                begin
                    be_next = be_reg;
                end
            endcase
        end
    end

    assign cfg.header_offset = hdr_reg;
    assign cfg.frame_base    = base_reg;
    assign cfg.big_endian    = be_reg;

    lpd_frame_tracker #(
        .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (s1_byte_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hdr_reg       <= '0;
            extra_reg     <= '0;
            be_reg        <= 1'b0;
            base_reg      <= lpd_pkg::POS_W'(LENGTH_FIELD_BYTES);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hdr_reg       <= hdr_next;
            extra_reg     <= extra_next;
            be_reg        <= be_next;
            base_reg      <= base_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_byte_reg <= stream_byte;
        end
        if (advance)
        begin
            out_byte_reg <= s1_byte_reg;
            out_res_reg  <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign frame_end    = out_res_reg.frame_end;
    assign frame_length = out_res_reg.frame_length;

`ifndef SYNTHESIS
    // length is reported only on the closing byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.frame_end |-> out_res_reg.frame_length == '0)
    else $error("frame_length set without frame_end");

    // input back-pressure only when both registers hold data and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
    else $error("input stalled while pipeline had room");

    // a byte leaving the input register lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
    else $error("byte lost between input and result register");
`endif

endmodule

@@ rtl/lpd_frame_tracker.sv @@
// per-frame byte counter, length field assembly and frame end detection
`timescale 1ns / 1ps

module lpd_frame_tracker #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [lpd_pkg::BYTE_W-1:0] data_byte,
    input  lpd_pkg::cfg_t              cfg,
    output lpd_pkg::res_t              res
);

    localparam logic [2:0] LAST_KEY = 3'(LENGTH_FIELD_BYTES - 1);

    logic [lpd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [lpd_pkg::REG_W-1:0] acc_reg, acc_next;
    logic [lpd_pkg::POS_W-1:0] total_reg, total_next;
    lpd_pkg::phase_t           phase_reg, phase_next;

    logic [lpd_pkg::POS_W-1:0] pos_inc;
    logic                      in_field;
    logic [lpd_pkg::POS_W-1:0] key_raw;
    logic                      key_last;
    logic [2:0]                key;
    logic [lpd_pkg::REG_W-1:0] acc_field;
    logic [lpd_pkg::POS_W-1:0] total_sum;
    logic                      short_frame;
    logic                      header_done;
    logic                      done;
    logic [lpd_pkg::POS_W-1:0] flen;

    // shared datapath
    always_comb
    begin
        pos_inc  = pos_reg + lpd_pkg::POS_W'(1);
        in_field = (pos_reg >= {3'b000, cfg.header_offset});
        key_raw  = pos_reg - {3'b000, cfg.header_offset};
        key_last = (key_raw >= lpd_pkg::POS_W'(LAST_KEY));
        key      = key_last ? LAST_KEY : key_raw[2:0];
        if (cfg.big_endian)
        begin
            acc_field = {acc_reg[23:0], data_byte};
        end
        else if (!key[2])
        begin
            acc_field = acc_reg | (lpd_pkg::REG_W'(data_byte) << {key[1:0], 3'b000});
        end
        else
        begin
            acc_field = acc_reg;
        end
        total_sum   = cfg.frame_base + {3'b000, acc_field};
        short_frame = ($signed({total_sum[lpd_pkg::POS_W-1], total_sum})
                       <= $signed({1'b0, pos_inc}));
        header_done = in_field && key_last;
    end

    // outputs
    always_comb
    begin
        case (phase_reg)
            lpd_pkg::PH_HEADER:
            begin
                done = header_done && short_frame;
                flen = pos_inc;
            end
            default:
            begin
                done = (pos_inc >= total_reg);
                flen = total_reg;
            end
        endcase
        res.frame_end    = done;
        res.frame_length = done ? flen[lpd_pkg::FLEN_W-1:0] : '0;
    end

    // next state
    always_comb
    begin
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        phase_next = phase_reg;
        if (step)
        begin
            pos_next = pos_inc;
            case (phase_reg)
                lpd_pkg::PH_HEADER:
                begin
                    if (in_field)
                    begin
                        acc_next = acc_field;
                    end
                    if (header_done && !short_frame)
                    begin
                        total_next = total_sum;
                        phase_next = lpd_pkg::PH_BODY;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (done)
            begin
                pos_next   = '0;
                acc_next   = '0;
                total_next = '0;
                phase_next = lpd_pkg::PH_HEADER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            acc_reg   <= '0;
            total_reg <= '0;
            phase_reg <= lpd_pkg::PH_HEADER;
        end
        else
        begin
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            total_reg <= total_next;
            phase_reg <= phase_next;
        end
    end

endmodule
